[design/weighted_return_ratio_macros.svh]
// ----------------------------------------------------------------------------
// Weighted return ratio assertion macros
// Concurrent check wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RETURN_RATIO_MACROS_SVH
`define WEIGHTED_RETURN_RATIO_MACROS_SVH

`ifndef SYNTHESIS

`define WRR_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("weighted_return_ratio: check failed");

`define WRR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weighted_return_ratio: check failed");

`define WRR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weighted_return_ratio: check failed");

`else

`define WRR_ASSERT_ALWAYS(label, cond)
`define WRR_ASSERT_IMPL(label, ante, cons)
`define WRR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/wrr_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted return ratio package
// Sizes, codes and fixed-point formats shared by the ratio block.
// ----------------------------------------------------------------------------
package wrr_pkg;

	localparam int CONSTITUENTS = 16;
	localparam int CIDX_W       = (CONSTITUENTS > 1) ? $clog2(CONSTITUENTS) : 1;

	localparam int IDX_W    = 4;
	localparam int VALUE_W  = 32;
	localparam int WEIGHT_W = 32;
	localparam int SUM_W    = 64;
	localparam int RATIO_W  = 16;

	localparam int RATIO_FRAC = 14;
	localparam int MUL_STEPS  = WEIGHT_W / 2;
	localparam int CNT_W      = $clog2(MUL_STEPS);

	localparam logic KIND_RETURN = 1'b0;
	localparam logic KIND_WEIGHT = 1'b1;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef logic [VALUE_W-1:0]  word_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [CIDX_W-1:0]   cidx_t;

endpackage

[design/weighted_return_ratio.sv]
// ----------------------------------------------------------------------------
// Weighted return ratio
// Running weighted return sum over weighted absolute return sum, Q1.14 out.
// ----------------------------------------------------------------------------
// A weight-load word or an out-of-range index is taken without leaving the
// idle state. A return update without a result runs through the accepting
// cycle, a step that fetches the old return, the radix-4 shift-add
// multipliers (two bits of weight per cycle, both sums in parallel) and the
// saturating accumulate. When a ratio is produced, the restoring divider
// adds a check, the 14 quotient bits and a step that loads the output
// register; a zero or clamped ratio skips the quotient bits. The load waits
// while the output register still holds an unaccepted ratio. The output
// register holds a finished ratio while the next word is accepted.
// ----------------------------------------------------------------------------
`include "weighted_return_ratio_macros.svh"

module weighted_return_ratio (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [wrr_pkg::IDX_W-1:0]            index,
	input  logic signed [wrr_pkg::VALUE_W-1:0]   value,
	input  logic                                 constituent_ready,
	input  logic                                 data_interrupted,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [wrr_pkg::RATIO_W-1:0]   ratio
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_SUM,
		ST_CHK,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                              state_q;
	wrr_pkg::word_t                      weight_q [wrr_pkg::CONSTITUENTS];
	wrr_pkg::word_t                      return_q [wrr_pkg::CONSTITUENTS];
	logic [wrr_pkg::CONSTITUENTS-1:0]    marks_q;
	logic                                all_ready_q;

	wrr_pkg::cidx_t                      idx_q;
	wrr_pkg::word_t                      new_q;
	logic                                intr_q;

	logic [31:0]                         mag_s_q, mag_a_q;
	logic [33:0]                         mag3_s_q, mag3_a_q;
	logic                                neg_s_q, neg_a_q;
	logic [31:0]                         hi_s_q, hi_a_q, lo_s_q, lo_a_q;
	logic [wrr_pkg::CNT_W-1:0]           cnt_q;

	wrr_pkg::sum_t                       ssum_q, asum_q;
	wrr_pkg::sum_t                       rem_q, den_q;
	logic [wrr_pkg::RATIO_FRAC:0]        quo_q;
	logic                                rneg_q;
	logic [wrr_pkg::RATIO_W-1:0]         ratio_q;
	logic                                out_valid_q;

	logic                                accept;
	logic                                in_range;
	wrr_pkg::cidx_t                      in_idx;
	logic [wrr_pkg::CONSTITUENTS-1:0]    set_vec;

	wrr_pkg::word_t                      old_ret, abs_new, abs_old;
	logic [32:0]                         ds, da;
	logic [31:0]                         mag_s, mag_a;
	logic [33:0]                         sum_s, sum_a;
	wrr_pkg::sum_t                       smag;
	logic [wrr_pkg::SUM_W:0]             rem_sh;
	logic                                q_bit;

	function automatic logic [33:0] mul_step(input logic [31:0] hi, input logic [1:0] dig,
		input logic [31:0] mag, input logic [33:0] mag3);
		logic [33:0] addend;
		case (dig)
			2'd0:    addend = '0;
			2'd1:    addend = {2'b00, mag};
			2'd2:    addend = {1'b0, mag, 1'b0};
			default: addend = mag3;
		endcase
		return {2'b00, hi} + addend;
	endfunction

	function automatic wrr_pkg::sum_t sat_add(input wrr_pkg::sum_t sum, input logic neg,
		input wrr_pkg::sum_t mag);
		logic [wrr_pkg::SUM_W+1:0] ext;
		logic [wrr_pkg::SUM_W+1:0] base;
		logic [wrr_pkg::SUM_W+1:0] r;
		ext  = {2'b00, mag};
		base = {{2{sum[wrr_pkg::SUM_W-1]}}, sum};
		r    = neg ? (base - ext) : (base + ext);
		if (r[wrr_pkg::SUM_W+1:wrr_pkg::SUM_W-1] == 3'b000 ||
			r[wrr_pkg::SUM_W+1:wrr_pkg::SUM_W-1] == 3'b111) begin
			return r[wrr_pkg::SUM_W-1:0];
		end else if (r[wrr_pkg::SUM_W+1]) begin
			return wrr_pkg::SUM_MIN;
		end else begin
			return wrr_pkg::SUM_MAX;
		end
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_range  = 32'(index) < wrr_pkg::CONSTITUENTS;
	assign in_idx    = wrr_pkg::CIDX_W'(index);
	assign out_valid = out_valid_q;
	assign ratio     = ratio_q;

	always_comb begin
		set_vec = '0;
		set_vec[in_idx] = constituent_ready;
	end

	assign old_ret = return_q[idx_q];
	assign ds      = {new_q[31], new_q} - {old_ret[31], old_ret};
	assign mag_s   = ds[32] ? 32'(-ds) : ds[31:0];
	assign abs_new = new_q[31] ? (32'd0 - new_q) : new_q;
	assign abs_old = old_ret[31] ? (32'd0 - old_ret) : old_ret;
	assign da      = {1'b0, abs_new} - {1'b0, abs_old};
	assign mag_a   = da[32] ? 32'(-da) : da[31:0];

	assign sum_s = mul_step(hi_s_q, lo_s_q[1:0], mag_s_q, mag3_s_q);
	assign sum_a = mul_step(hi_a_q, lo_a_q[1:0], mag_a_q, mag3_a_q);

	assign smag   = ssum_q[wrr_pkg::SUM_W-1] ? (wrr_pkg::SUM_W'(0) - ssum_q) : ssum_q;
	assign rem_sh = {rem_q, 1'b0};
	assign q_bit  = rem_sh >= {1'b0, den_q};

	// weight and return tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wrr_pkg::CONSTITUENTS; i++) begin
				weight_q[i] <= '0;
				return_q[i] <= '0;
			end
		end else begin
			if (accept && in_range && kind == wrr_pkg::KIND_WEIGHT) begin
				weight_q[in_idx] <= value;
			end
			if (state_q == ST_PREP) begin
				return_q[idx_q] <= new_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			marks_q     <= '0;
			all_ready_q <= 1'b0;
			idx_q       <= '0;
			new_q       <= '0;
			intr_q      <= 1'b0;
			mag_s_q     <= '0;
			mag_a_q     <= '0;
			mag3_s_q    <= '0;
			mag3_a_q    <= '0;
			neg_s_q     <= 1'b0;
			neg_a_q     <= 1'b0;
			hi_s_q      <= '0;
			hi_a_q      <= '0;
			lo_s_q      <= '0;
			lo_a_q      <= '0;
			cnt_q       <= '0;
			ssum_q      <= '0;
			asum_q      <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			quo_q       <= '0;
			rneg_q      <= 1'b0;
			ratio_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_range && kind == wrr_pkg::KIND_RETURN) begin
						idx_q  <= in_idx;
						new_q  <= value;
						intr_q <= data_interrupted;
						if (!all_ready_q) begin
							marks_q     <= marks_q | set_vec;
							all_ready_q <= &(marks_q | set_vec);
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					mag_s_q  <= mag_s;
					mag_a_q  <= mag_a;
					mag3_s_q <= {2'b00, mag_s} + {1'b0, mag_s, 1'b0};
					mag3_a_q <= {2'b00, mag_a} + {1'b0, mag_a, 1'b0};
					neg_s_q  <= ds[32];
					neg_a_q  <= da[32];
					hi_s_q   <= '0;
					hi_a_q   <= '0;
					lo_s_q   <= weight_q[idx_q];
					lo_a_q   <= weight_q[idx_q];
					cnt_q    <= '0;
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					hi_s_q <= sum_s[33:2];
					hi_a_q <= sum_a[33:2];
					lo_s_q <= {sum_s[1:0], lo_s_q[31:2]};
					lo_a_q <= {sum_a[1:0], lo_a_q[31:2]};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == wrr_pkg::CNT_W'(wrr_pkg::MUL_STEPS - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					ssum_q <= sat_add(ssum_q, neg_s_q, {hi_s_q, lo_s_q});
					asum_q <= sat_add(asum_q, neg_a_q, {hi_a_q, lo_a_q});
					state_q <= (all_ready_q && !intr_q) ? ST_CHK : ST_IDLE;
				end
				ST_CHK: begin
					rneg_q <= ssum_q[wrr_pkg::SUM_W-1];
					rem_q  <= smag;
					den_q  <= asum_q;
					cnt_q  <= '0;
					if (asum_q[wrr_pkg::SUM_W-1] || asum_q == '0) begin
						quo_q   <= '0;
						state_q <= ST_OUT;
					end else if (smag >= asum_q) begin
						quo_q   <= {1'b1, {wrr_pkg::RATIO_FRAC{1'b0}}};
						state_q <= ST_OUT;
					end else begin
						quo_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= q_bit ? wrr_pkg::SUM_W'(rem_sh - {1'b0, den_q})
						: rem_sh[wrr_pkg::SUM_W-1:0];
					quo_q <= {quo_q[wrr_pkg::RATIO_FRAC-1:0], q_bit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wrr_pkg::CNT_W'(wrr_pkg::RATIO_FRAC - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						ratio_q <= rneg_q
							? (wrr_pkg::RATIO_W'(0) - wrr_pkg::RATIO_W'(quo_q))
							: wrr_pkg::RATIO_W'(quo_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`WRR_ASSERT_ALWAYS(a_ready_sticky, !$fell(all_ready_q))
	`WRR_ASSERT_NEXT(a_update_busy, accept && in_range && kind == wrr_pkg::KIND_RETURN, !in_ready)
	`WRR_ASSERT_IMPL(a_rem_below_den, state_q == ST_DIV, rem_q < den_q)
	`WRR_ASSERT_IMPL(a_ratio_range, out_valid, ratio >= -16'sd16384 && ratio <= 16'sd16384)

endmodule
